// File: rtl/fkh_pkg.sv
// ----------------------------------------------------------------------------
// fkh_pkg
// Shared types, step schedule, tables and fixed-point helpers of the
// joint hierarchy world transform core.
// ----------------------------------------------------------------------------
package fkh_pkg;

	localparam int MAX_JOINTS_DEF = 256;

	localparam logic [8:0] ROOT_CODE = 9'd256;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_PARENT = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;

	localparam logic [5:0] STEP_V     = 6'd0;
	localparam logic [5:0] STEP_P     = 6'd3;
	localparam logic [5:0] STEP_S     = 6'd13;
	localparam logic [5:0] STEP_RLOAD = 6'd14;
	localparam logic [5:0] STEP_R     = 6'd16;
	localparam logic [5:0] STEP_Q     = 6'd25;
	localparam logic [5:0] STEP_END   = 6'd41;

	localparam logic [1:0] PA [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0};
	localparam logic [1:0] PB [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd1};

	localparam logic [1:0] RV_ROW [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam logic [1:0] RV_COL [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

	localparam logic [15:0] QNEG = 16'b0100_0010_1000_1110;

	typedef struct packed {
		logic [2:0][15:0] s;
		logic [3:0][15:0] q;
		logic [2:0][31:0] t;
	} xform_t;

	typedef struct packed {
		logic       load;
		logic       read;
		logic       run;
		logic [5:0] step;
		logic       finish;
	} cmd_t;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -64'sh0000_0000_8000_0000) return -32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
		if (x > 64'sh7FFF) return 16'sh7FFF;
		if (x < -64'sh8000) return -16'sh8000;
		return x[15:0];
	endfunction

endpackage

// File: rtl/joint_hierarchy_world_transform_core.sv
// ----------------------------------------------------------------------------
// joint_hierarchy_world_transform_core
// Forward kinematics over a translation/rotation/scale joint hierarchy.
// ----------------------------------------------------------------------------
// Each joint is accepted, reads its parent from the joint store, runs 41
// products through the single shared 32x19 multiplier and its accumulator,
// and is written back to the output register and, unless the store is full,
// to the store, once the output register is free or its result is taken.
// The next joint is accepted in the cycle after write-back, while its
// predecessor's result may still wait on the master side. The store holds
// MAX_JOINTS world transforms; its contents are undefined until written and need no clearing after reset.
module joint_hierarchy_world_transform_core #(
	parameter int MAX_JOINTS = fkh_pkg::MAX_JOINTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// parent_index, local_tx, local_ty, local_tz, local_qw, local_qx, local_qy,
	// local_qz, local_sx, local_sy, local_sz, zero fill
	input  logic [223:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// world_tx, world_ty, world_tz, world_qw, world_qx, world_qy, world_qz,
	// world_sx, world_sy, world_sz
	output logic [207:0] m_tdata,
	// status
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	fkh_pkg::cmd_t cmd;

	fkh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	fkh_dp #(
		.MAX_JOINTS (MAX_JOINTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// File: rtl/fkh_ctrl.sv
// ----------------------------------------------------------------------------
// fkh_ctrl
// Sequencer: accepts a joint, reads its parent, steps the shared multiplier
// schedule and hands the result to the output register.
// ----------------------------------------------------------------------------
module fkh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output fkh_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		IDLE = 4'b0001,
		READ = 4'b0010,
		RUN  = 4'b0100,
		FIN  = 4'b1000
	} state_t;

	state_t     state_q;
	logic [5:0] step_q;
	logic       mvalid_q;
	logic       fin_ok;

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = mvalid_q;
	assign fin_ok   = (state_q == FIN) && (!mvalid_q || m_tready);

	always_comb begin
		cmd.load   = s_tvalid && s_tready;
		cmd.read   = (state_q == READ);
		cmd.run    = (state_q == RUN);
		cmd.step   = step_q;
		cmd.finish = fin_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			step_q   <= '0;
			mvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (s_tvalid) state_q <= READ;
				READ: begin
					step_q  <= '0;
					state_q <= RUN;
				end
				RUN: begin
					if (step_q == fkh_pkg::STEP_END) state_q <= FIN;
					else step_q <= step_q + 6'd1;
				end
				FIN: if (fin_ok) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
			if (fin_ok) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

	a_load_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == READ) else $error("load not followed by read");
	a_run_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN && step_q == fkh_pkg::STEP_END) |=> state_q == FIN)
		else $error("schedule overran");
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid) else $error("finished result not presented");

endmodule

// File: rtl/fkh_dp.sv
// ----------------------------------------------------------------------------
// fkh_dp
// Datapath: joint store, one shared 32x19 multiplier with accumulator,
// rounding and saturation, output register.
// ----------------------------------------------------------------------------
module fkh_dp #(
	parameter int MAX_JOINTS = fkh_pkg::MAX_JOINTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fkh_pkg::cmd_t   cmd,
	input  logic [223:0]    s_tdata,
	input  logic            s_tlast,
	output logic [207:0]    m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	localparam int AW = $clog2(MAX_JOINTS);
	localparam int CW = $clog2(MAX_JOINTS + 1);

	fkh_pkg::xform_t mem [MAX_JOINTS];
	fkh_pkg::xform_t loc_q, prt_q, wld;

	logic [8:0]    par_q;
	logic          last_q, hasp_q;
	logic [1:0]    stat_q;
	logic [CW-1:0] cnt_q;

	logic [8:0] in_par;
	logic       in_full, in_bad;

	logic signed [31:0] op_a;
	logic signed [18:0] op_b;
	logic               op_neg;
	logic signed [50:0] prod_q;
	logic [5:0]         sd_q;
	logic               dv_q, neg_q;
	logic [5:0]         ridx, qidx;
	logic [1:0]         qg, qj;

	logic signed [31:0] v_q  [3];
	logic signed [31:0] p_q  [10];
	logic signed [18:0] r_q  [9];
	logic signed [15:0] ws_q [3];
	logic signed [31:0] wt_q [3];
	logic signed [15:0] wq_q [4];
	logic signed [53:0] acc_q, acc_d, prod_x;
	logic signed [34:0] e [9];
	logic [5:0]         dr, dq;

	assign in_par  = s_tdata[8:0];
	assign in_full = (cnt_q == CW'(MAX_JOINTS));
	assign in_bad  = (in_par != fkh_pkg::ROOT_CODE) && !(32'(in_par) < 32'(cnt_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			loc_q  <= fkh_pkg::xform_t'(s_tdata[216:9]);
			par_q  <= in_par;
			last_q <= s_tlast;
			hasp_q <= (in_par != fkh_pkg::ROOT_CODE) && !in_bad;
			stat_q <= in_full ? fkh_pkg::ST_FULL : (in_bad ? fkh_pkg::ST_BAD_PARENT : fkh_pkg::ST_OK);
		end
		if (cmd.read) prt_q <= mem[AW'(par_q)];
		if (cmd.finish && stat_q != fkh_pkg::ST_FULL) mem[AW'(cnt_q)] <= wld;
	end

	assign ridx = cmd.step - fkh_pkg::STEP_R;
	assign qidx = cmd.step - fkh_pkg::STEP_Q;
	assign qg   = qidx[3:2];
	assign qj   = qidx[1:0];

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_neg = 1'b0;
		if (cmd.step < fkh_pkg::STEP_P) begin
			op_a = $signed(loc_q.t[cmd.step[1:0]]);
			op_b = 19'($signed(prt_q.s[cmd.step[1:0]]));
		end else if (cmd.step < fkh_pkg::STEP_S) begin
			op_a = 32'($signed(prt_q.q[fkh_pkg::PA[4'(cmd.step - fkh_pkg::STEP_P)]]));
			op_b = 19'($signed(prt_q.q[fkh_pkg::PB[4'(cmd.step - fkh_pkg::STEP_P)]]));
		end else if (cmd.step < fkh_pkg::STEP_R) begin
			op_a = 32'($signed(prt_q.s[2'(cmd.step - fkh_pkg::STEP_S)]));
			op_b = 19'($signed(loc_q.s[2'(cmd.step - fkh_pkg::STEP_S)]));
		end else if (cmd.step < fkh_pkg::STEP_Q) begin
			op_a = v_q[fkh_pkg::RV_COL[ridx[3:0]]];
			op_b = r_q[ridx[3:0]];
		end else if (cmd.step < fkh_pkg::STEP_END) begin
			op_a   = 32'($signed(prt_q.q[qj]));
			op_b   = 19'($signed(loc_q.q[qg ^ qj]));
			op_neg = fkh_pkg::QNEG[qidx[3:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
		end else begin
			dv_q <= cmd.run;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		sd_q   <= cmd.step;
		neg_q  <= op_neg;
	end

	assign e[0] = 35'(p_q[0]) + 35'(p_q[1]) - 35'(p_q[2]) - 35'(p_q[3]);
	assign e[1] = (35'(p_q[4]) - 35'(p_q[5])) <<< 1;
	assign e[2] = (35'(p_q[6]) + 35'(p_q[7])) <<< 1;
	assign e[3] = (35'(p_q[4]) + 35'(p_q[5])) <<< 1;
	assign e[4] = 35'(p_q[0]) - 35'(p_q[1]) + 35'(p_q[2]) - 35'(p_q[3]);
	assign e[5] = (35'(p_q[8]) - 35'(p_q[9])) <<< 1;
	assign e[6] = (35'(p_q[6]) - 35'(p_q[7])) <<< 1;
	assign e[7] = (35'(p_q[8]) + 35'(p_q[9])) <<< 1;
	assign e[8] = 35'(p_q[0]) - 35'(p_q[1]) - 35'(p_q[2]) + 35'(p_q[3]);

	assign dr     = sd_q - fkh_pkg::STEP_R;
	assign dq     = sd_q - fkh_pkg::STEP_Q;
	assign prod_x = 54'(prod_q);

	always_comb begin
		acc_d = acc_q;
		if (sd_q >= fkh_pkg::STEP_R && sd_q < fkh_pkg::STEP_Q) begin
			acc_d = ((fkh_pkg::RV_COL[dr[3:0]] == 2'd0) ? 54'sd0 : acc_q) + prod_x;
		end else if (sd_q >= fkh_pkg::STEP_Q && sd_q < fkh_pkg::STEP_END) begin
			acc_d = ((dq[1:0] == 2'd0) ? 54'sd0 : acc_q) + (neg_q ? -prod_x : prod_x);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run && cmd.step == fkh_pkg::STEP_RLOAD) begin
			for (int i = 0; i < 9; i++) r_q[i] <= 19'(fkh_pkg::rnd(64'(e[i]), 15));
		end
		if (dv_q) begin
			acc_q <= acc_d;
			if (sd_q < fkh_pkg::STEP_P) begin
				v_q[sd_q[1:0]] <= fkh_pkg::sat32(fkh_pkg::rnd(64'(prod_q), 8));
			end else if (sd_q < fkh_pkg::STEP_S) begin
				p_q[4'(sd_q - fkh_pkg::STEP_P)] <= prod_q[31:0];
			end else if (sd_q < fkh_pkg::STEP_R) begin
				ws_q[2'(sd_q - fkh_pkg::STEP_S)] <= fkh_pkg::sat16(fkh_pkg::rnd(64'(prod_q), 8));
			end else if (sd_q < fkh_pkg::STEP_Q) begin
				if (fkh_pkg::RV_COL[dr[3:0]] == 2'd2)
					wt_q[fkh_pkg::RV_ROW[dr[3:0]]] <= fkh_pkg::sat32(
						64'($signed(prt_q.t[fkh_pkg::RV_ROW[dr[3:0]]]))
						+ fkh_pkg::rnd(64'(acc_d), 15));
			end else if (sd_q < fkh_pkg::STEP_END) begin
				if (dq[1:0] == 2'd3)
					wq_q[dq[3:2]] <= fkh_pkg::sat16(fkh_pkg::rnd(64'(acc_d), 15));
			end
		end
	end

	always_comb begin
		wld = loc_q;
		if (hasp_q) begin
			for (int i = 0; i < 3; i++) wld.t[i] = wt_q[i];
			for (int i = 0; i < 4; i++) wld.q[i] = wq_q[i];
			for (int i = 0; i < 3; i++) wld.s[i] = ws_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_tdata <= wld;
			m_tuser <= stat_q;
			m_tlast <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.finish) begin
			if (last_q) cnt_q <= '0;
			else if (stat_q != fkh_pkg::ST_FULL) cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule

// File: bench/tb_joint_hierarchy_world_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_hierarchy_world_transform_core
// Streams skeletons into the forward kinematics core and checks every world
// transform against a bit-accurate predictor held in a small scoreboard. The
// run covers field extremes, root, bad and over-capacity parents, and random
// skeletons, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_joint_hierarchy_world_transform_core;

	class pose_scoreboard;
		longint tstore[3][256];
		longint qstore[4][256];
		longint sstore[3][256];
		int joints_held;
		logic [210:0] pending[$];
		int errors;

		function new();
			joints_held = 0;
			errors = 0;
		endfunction

		function longint rsh(longint x, int n);
			return (x + (64'sd1 <<< (n - 1))) >>> n;
		endfunction

		function longint clip(longint x, longint lo, longint hi);
			return x < lo ? lo : (x > hi ? hi : x);
		endfunction

		function void note_joint(logic [223:0] d, logic lst);
			longint lt[3], lq[4], ls[3], v[3], r[3][3], wt[3], wq[4], ws[3];
			longint w, x, y, z, acc;
			int p, i, k;
			bit full, linked;
			logic [1:0] st;
			logic [207:0] e;
			p = d[8:0];
			for (i = 0; i < 3; i++) lt[i] = signed'(d[9 + 32 * i +: 32]);
			for (i = 0; i < 4; i++) lq[i] = signed'(d[105 + 16 * i +: 16]);
			for (i = 0; i < 3; i++) ls[i] = signed'(d[169 + 16 * i +: 16]);
			full = joints_held >= 256;
			linked = 0;
			st = fkh_pkg::ST_OK;
			if (p != fkh_pkg::ROOT_CODE) begin
				if (p < joints_held) linked = 1;
				else st = fkh_pkg::ST_BAD_PARENT;
			end
			if (full) st = fkh_pkg::ST_FULL;
			if (!linked) begin
				wt = lt;
				wq = lq;
				ws = ls;
			end else begin
				w = qstore[0][p];
				x = qstore[1][p];
				y = qstore[2][p];
				z = qstore[3][p];
				for (i = 0; i < 3; i++)
					v[i] = clip(rsh(lt[i] * sstore[i][p], 8), -64'sd2147483648, 64'sd2147483647);
				r[0][0] = w * w + x * x - y * y - z * z;
				r[0][1] = 2 * (x * y - w * z);
				r[0][2] = 2 * (x * z + w * y);
				r[1][0] = 2 * (x * y + w * z);
				r[1][1] = w * w - x * x + y * y - z * z;
				r[1][2] = 2 * (y * z - w * x);
				r[2][0] = 2 * (x * z - w * y);
				r[2][1] = 2 * (y * z + w * x);
				r[2][2] = w * w - x * x - y * y + z * z;
				for (i = 0; i < 3; i++) begin
					acc = 0;
					for (k = 0; k < 3; k++) acc += rsh(r[i][k], 15) * v[k];
					wt[i] = clip(tstore[i][p] + rsh(acc, 15), -64'sd2147483648, 64'sd2147483647);
				end
				wq[0] = w * lq[0] - x * lq[1] - y * lq[2] - z * lq[3];
				wq[1] = w * lq[1] + x * lq[0] + y * lq[3] - z * lq[2];
				wq[2] = w * lq[2] - x * lq[3] + y * lq[0] + z * lq[1];
				wq[3] = w * lq[3] + x * lq[2] - y * lq[1] + z * lq[0];
				for (i = 0; i < 4; i++) wq[i] = clip(rsh(wq[i], 15), -32768, 32767);
				for (i = 0; i < 3; i++)
					ws[i] = clip(rsh(sstore[i][p] * ls[i], 8), -32768, 32767);
			end
			if (!full) begin
				for (i = 0; i < 3; i++) tstore[i][joints_held] = wt[i];
				for (i = 0; i < 4; i++) qstore[i][joints_held] = wq[i];
				for (i = 0; i < 3; i++) sstore[i][joints_held] = ws[i];
				joints_held++;
			end
			if (lst) joints_held = 0;
			for (i = 0; i < 3; i++) e[32 * i +: 32] = wt[i][31:0];
			for (i = 0; i < 4; i++) e[96 + 16 * i +: 16] = wq[i][15:0];
			for (i = 0; i < 3; i++) e[160 + 16 * i +: 16] = ws[i][15:0];
			pending.insert(pending.size(), {lst, st, e});
		endfunction

		function void check_pose(logic [207:0] d, logic [1:0] st, logic lst);
			logic [210:0] e;
			int i, lo, wd;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h status %0d last %0d", $time, d, st, lst);
				errors++;
				return;
			end
			e = pending.pop_front();
			for (i = 0; i < 10; i++) begin
				lo = i < 3 ? 32 * i : 96 + 16 * (i - 3);
				wd = i < 3 ? 32 : 16;
				if ((e[lo +: 32] & ((64'd1 << wd) - 1)) !== (d[lo +: 32] & ((64'd1 << wd) - 1)))
				begin
					$display("%0t: field %0d expected %h actual %h", $time, i,
						e[lo +: 32] & ((64'd1 << wd) - 1), d[lo +: 32] & ((64'd1 << wd) - 1));
					errors++;
				end
			end
			if (e[209:208] !== st) begin
				$display("%0t: status expected %0d actual %0d", $time, e[209:208], st);
				errors++;
			end
			if (e[210] !== lst) begin
				$display("%0t: last expected %0d actual %0d", $time, e[210], lst);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [223:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [207:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	pose_scoreboard poses = new();
	bit calm = 0;
	int cycles = 0;
	int stall_left = 0;

	joint_hierarchy_world_transform_core DUT (.*);

	always #10 clk = ~clk;

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("tb_joint_hierarchy_world_transform_core NOT OK");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) poses.check_pose(m_tdata, m_tuser, m_tlast);
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 0;
		end else begin
			stall_left = gap_len();
			m_tready <= stall_left == 0;
		end
	end

	task automatic put_joint(int p, longint tx, longint ty, longint tz, longint qw, longint qx,
			longint qy, longint qz, longint sx, longint sy, longint sz, bit lst);
		logic [223:0] d;
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		d = '0;
		d[8:0] = p;
		d[40:9] = tx;
		d[72:41] = ty;
		d[104:73] = tz;
		d[120:105] = qw;
		d[136:121] = qx;
		d[152:137] = qy;
		d[168:153] = qz;
		d[184:169] = sx;
		d[200:185] = sy;
		d[216:201] = sz;
		s_tdata <= d;
		s_tlast <= lst;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		poses.note_joint(d, lst);
		@(negedge clk);
	endtask

	function longint rnd_val(int bits, bit tame);
		longint v;
		v = {$urandom, $urandom};
		if (tame) v = $urandom_range(0, 1 << (bits - 4)) - (1 << (bits - 5));
		return v;
	endfunction

	task automatic run_skeleton(int n, int bad_pct);
		int j, held, p, r;
		bit tame;
		for (j = 0; j < n; j++) begin
			held = j < 256 ? j : 256;
			r = $urandom_range(0, 99);
			if (r < 12 || held == 0) p = fkh_pkg::ROOT_CODE;
			else if (r < 12 + bad_pct)
				p = ($urandom_range(0, 1) && held < 256) ? $urandom_range(held, 255)
					: $urandom_range(257, 511);
			else p = $urandom_range(0, held - 1);
			tame = $urandom_range(0, 2) != 0;
			put_joint(p, rnd_val(32, tame), rnd_val(32, tame), rnd_val(32, tame),
				rnd_val(16, 0), rnd_val(16, 0), rnd_val(16, 0), rnd_val(16, 0),
				tame ? $urandom_range(128, 512) : rnd_val(16, 0),
				tame ? $urandom_range(128, 512) : rnd_val(16, 0),
				tame ? $urandom_range(128, 512) : rnd_val(16, 0), j == n - 1);
		end
	endtask

	initial begin
		int sent;
		int n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		put_joint(fkh_pkg::ROOT_CODE, 32'h7FFFFFFF, 32'h80000000, 0, 32767, 0, 0, 0,
			256, 256, 256, 0);
		put_joint(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32767, 0, 0, 0,
			32'h7FFF, 32'h8000, 256, 0);
		put_joint(fkh_pkg::ROOT_CODE, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
		put_joint(2, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		put_joint(3, 32'h00010000, 32'hFFFF0000, 32'h00008000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h0100, 16'hFF00, 0, 0);
		put_joint(4, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 23170, 0, 23170, 0,
			256, 512, 128, 0);
		put_joint(255, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 0);
		put_joint(6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		put_joint(511, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 0);
		put_joint(257, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
		put_joint(8, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0);
		put_joint(10, 32'h00000080, 32'hFFFFFF80, 32'h7FFFFF80, 16'h4000, 16'hC000,
			16'h4000, 16'hC000, 16'h0080, 16'hFF80, 16'h0001, 0);
		put_joint(11, 32'hFFFF8000, 32'h00007FFF, 0, 0, 32767, 0, 0, 256, 256, 256, 1);
		put_joint(0, 5, 6, 7, 32767, 0, 0, 0, 256, 256, 256, 1);
		put_joint(fkh_pkg::ROOT_CODE, 1, 1, 1, 32767, 0, 0, 0, 256, 256, 256, 1);
		sent = 15;
		calm = 1;
		run_skeleton(262, 5);
		calm = 0;
		sent += 262;
		while (sent < 700) begin
			calm = $urandom_range(0, 5) == 0;
			n = $urandom_range(1, 24);
			run_skeleton(n, $urandom_range(0, 20));
			sent = sent + n;
		end
		s_tvalid <= 0;
		calm = 0;
		while (poses.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (poses.errors == 0) $display("tb_joint_hierarchy_world_transform_core OK");
		else $display("tb_joint_hierarchy_world_transform_core NOT OK");
		$finish;
	end
endmodule
